>>> rtl/core/two_tier_transposition_table_defines.svh
// assertion macros for the two-tier transposition table
`ifndef TWO_TIER_TRANSPOSITION_TABLE_DEFINES_SVH
`define TWO_TIER_TRANSPOSITION_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
`define TTT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TTT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TTT_ASSERT(lbl, prop, msg)
`define TTT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/core/ttt_pkg.sv
// shared types and constants for the two-tier transposition table
`timescale 1ns / 1ps
package ttt_pkg;

    localparam int KEY_W     = 64;
    localparam int DEPTH_W   = 8;
    localparam int EVAL_W    = 16;
    localparam int BOUND_W   = 2;
    localparam int ENTRY_W   = KEY_W + DEPTH_W + EVAL_W + BOUND_W;
    localparam int TABLE_ENTRIES_DEF = 1024;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
    localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd1;
    localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd2;
    localparam logic [BOUND_W-1:0] BOUND_NONE  = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic [DEPTH_W-1:0]        depth;
        logic signed [EVAL_W-1:0]  eval;
        logic [BOUND_W-1:0]        bound;
    } entry_t;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic [DEPTH_W-1:0]        depth;
        logic signed [EVAL_W-1:0]  alpha;
        logic signed [EVAL_W-1:0]  beta;
    } probe_req_t;

    typedef struct packed {
        logic                      hit;
        logic signed [EVAL_W-1:0]  score;
    } probe_rsp_t;

endpackage

>>> rtl/core/ttt_ram.sv
// single-write, registered-read memory for one table tier
`timescale 1ns / 1ps
module ttt_ram
    import ttt_pkg::*;
#(
    parameter int DEPTH = TABLE_ENTRIES_DEF,
    parameter int WIDTH = ENTRY_W
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/ttt_probe.sv
// match and bound check of one stored entry against a lookup
`timescale 1ns / 1ps
module ttt_probe
    import ttt_pkg::*;
(
    input  entry_t     ent,
    input  probe_req_t req,
    output probe_rsp_t rsp
);

    logic usable;

    assign usable = (ent.key == req.key) && (ent.depth > req.depth);

    always_comb
    begin
        rsp = '0;
        if (usable)
        begin
            case (ent.bound)
                BOUND_EXACT:
                begin
                    rsp.hit   = 1'b1;
                    rsp.score = ent.eval;
                end
                BOUND_UPPER:
                begin
                    if ($signed(ent.eval) <= $signed(req.alpha))
                    begin
                        rsp.hit   = 1'b1;
                        rsp.score = req.alpha;
                    end
                end
                BOUND_LOWER:
                begin
                    if ($signed(ent.eval) >= $signed(req.beta))
                    begin
                        rsp.hit   = 1'b1;
                        rsp.score = req.beta;
                    end
                end
                BOUND_NONE:
                begin
                    rsp = '0;
                end
                default:
                begin
                    rsp = '0;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/two_tier_transposition_table.sv
// two-tier transposition table: depth-preferred primary, always-replace secondary
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  input   | in_valid in_ready op key depth eval bound_kind  | in
//          | alpha beta                                      |
//  output  | out_valid out_ready hit score                   | out
//
//  record: accept, read, write back; lookup: accept, read, probe, plus a second tier probe on a miss
//  index is key mod TABLE_ENTRIES: free for a power of two, else four 16-bit digits,
//  each reduced by one shared multiplier (estimate, multiply-subtract, fix)
//  after reset a clearing pass zeroes both tiers, in_ready low
//  a lookup result waits in the output register; a new transaction is taken meanwhile
//  the sequencer holds at the result step only while the output register is still full
`timescale 1ns / 1ps
`include "two_tier_transposition_table_defines.svh"
module two_tier_transposition_table
    import ttt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      op,
    input  logic [KEY_W-1:0]          key,
    input  logic [DEPTH_W-1:0]        depth,
    input  logic signed [EVAL_W-1:0]  eval,
    input  logic [BOUND_W-1:0]        bound_kind,
    input  logic signed [EVAL_W-1:0]  alpha,
    input  logic signed [EVAL_W-1:0]  beta,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      hit,
    output logic signed [EVAL_W-1:0]  score
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam logic IS_POW2 = (TABLE_ENTRIES == (1 << IW));
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    // digit reduction: y = {r, digit}, q = (y >> (IW-1)) * MU >> QW, r = y - q*M, fix
    localparam int DIG_W = 16;
    localparam int YW    = IW + DIG_W;
    localparam int QW    = DIG_W + 1;
    localparam int MBW   = (IW + 1 > QW) ? IW + 1 : QW;
    localparam int PW    = QW + MBW;
    localparam int TW    = IW + 2;
    localparam logic [63:0]    MU_FULL = (64'd1 << YW) / 64'(TABLE_ENTRIES);
    localparam logic [MBW-1:0] MU_B    = MBW'(MU_FULL);
    localparam logic [MBW-1:0] MOD_B   = MBW'(TABLE_ENTRIES);
    localparam logic [TW-1:0]  MOD_T   = TW'(TABLE_ENTRIES);
    localparam logic [TW-1:0]  MOD2_T  = TW'(2 * TABLE_ENTRIES);
    localparam logic [1:0]     TOP_DIG = 2'd3;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIVQ  = 3'd2;
    localparam logic [2:0] ST_DIVP  = 3'd3;
    localparam logic [2:0] ST_DIVF  = 3'd4;
    localparam logic [2:0] ST_READ  = 3'd5;
    localparam logic [2:0] ST_PRIM  = 3'd6;
    localparam logic [2:0] ST_SEC   = 3'd7;

    logic [2:0]               state_reg, state_next;
    logic [IW-1:0]            clr_reg, clr_next;
    logic [1:0]               dig_reg, dig_next;
    logic [QW-1:0]            q_reg, q_next;
    logic [TW-1:0]            t_reg, t_next;
    logic [IW-1:0]            idx_reg, idx_next;
    logic                     op_reg;
    logic [KEY_W-1:0]         key_reg;
    logic [DEPTH_W-1:0]       depth_reg;
    logic signed [EVAL_W-1:0] eval_reg;
    logic [BOUND_W-1:0]       bound_reg;
    logic signed [EVAL_W-1:0] alpha_reg;
    logic signed [EVAL_W-1:0] beta_reg;
    logic                     out_valid_reg, out_valid_next;
    logic                     hit_reg;
    logic signed [EVAL_W-1:0] score_reg;

    logic       accept;
    logic       out_free;
    logic       load_out;
    probe_rsp_t load_rsp;
    logic [YW-1:0]  div_y;
    logic [QW-1:0]  mul_a;
    logic [MBW-1:0] mul_b;
    logic [PW-1:0]  prod;
    logic [PW-1:0]  t_full;
    logic [TW-1:0]  t_fix;

    logic          prim_wr_en, sec_wr_en, rd_en;
    logic [IW-1:0] wr_addr;
    entry_t        wr_ent, prim_ent, sec_ent, probe_ent;
    probe_req_t    req;
    probe_rsp_t    rsp;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign score     = score_reg;

    // shared multiplier: quotient estimate, then quotient times modulus
    assign div_y  = {idx_reg, key_reg[dig_reg * DIG_W +: DIG_W]};
    assign mul_a  = (state_reg == ST_DIVP) ? q_reg : div_y[YW-1:IW-1];
    assign mul_b  = (state_reg == ST_DIVP) ? MOD_B : MU_B;
    assign prod   = PW'(mul_a) * PW'(mul_b);
    assign t_full = PW'(div_y) - prod;
    assign t_fix  = (t_reg >= MOD2_T) ? (t_reg - MOD2_T)
                  : (t_reg >= MOD_T) ? (t_reg - MOD_T) : t_reg;

    assign rd_en   = (state_reg == ST_READ);
    assign wr_addr = (state_reg == ST_CLEAR) ? clr_reg : idx_reg;
    assign wr_ent  = (state_reg == ST_CLEAR) ? entry_t'('0)
                   : entry_t'{key: key_reg, depth: depth_reg, eval: eval_reg, bound: bound_reg};
    assign sec_wr_en  = (state_reg == ST_CLEAR)
                     || (state_reg == ST_PRIM && op_reg == OP_RECORD);
    assign prim_wr_en = (state_reg == ST_CLEAR)
                     || (state_reg == ST_PRIM && op_reg == OP_RECORD
                         && depth_reg > prim_ent.depth);

    assign probe_ent = (state_reg == ST_SEC) ? sec_ent : prim_ent;
    assign req = '{key: key_reg, depth: depth_reg, alpha: alpha_reg, beta: beta_reg};

    ttt_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (ENTRY_W)
    ) u_prim (
        .clk     (clk),
        .wr_en   (prim_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_ent),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (prim_ent)
    );

    ttt_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (ENTRY_W)
    ) u_sec (
        .clk     (clk),
        .wr_en   (sec_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_ent),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (sec_ent)
    );

    ttt_probe u_probe (
        .ent (probe_ent),
        .req (req),
        .rsp (rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        dig_next       = dig_reg;
        q_next         = q_reg;
        t_next         = t_reg;
        idx_next       = idx_reg;
        load_out       = 1'b0;
        load_rsp       = rsp;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    dig_next = TOP_DIG;
                    if (IS_POW2)
                    begin
                        idx_next   = key[IW-1:0];
                        state_next = ST_READ;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = ST_DIVQ;
                    end
                end
            end
            ST_DIVQ:
            begin
                q_next     = prod[2*QW-1:QW];
                state_next = ST_DIVP;
            end
            ST_DIVP:
            begin
                t_next     = t_full[TW-1:0];
                state_next = ST_DIVF;
            end
            ST_DIVF:
            begin
                idx_next = t_fix[IW-1:0];
                dig_next = dig_reg - 1'b1;
                if (dig_reg == '0)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_DIVQ;
                end
            end
            ST_READ:
            begin
                state_next = ST_PRIM;
            end
            ST_PRIM:
            begin
                if (op_reg == OP_RECORD)
                begin
                    state_next = ST_IDLE;
                end
                else if (!rsp.hit)
                begin
                    state_next = ST_SEC;
                end
                else if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SEC:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
        q_reg   <= q_next;
        t_reg   <= t_next;
        idx_reg <= idx_next;
        if (accept)
        begin
            op_reg    <= op;
            key_reg   <= key;
            depth_reg <= depth;
            eval_reg  <= eval;
            bound_reg <= bound_kind;
            alpha_reg <= alpha;
            beta_reg  <= beta;
        end
        if (load_out)
        begin
            hit_reg   <= load_rsp.hit;
            score_reg <= load_rsp.score;
        end
    end

    `TTT_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "ready high right after a transaction")
    `TTT_ASSERT(a_miss_zero, !(out_valid_reg && !hit_reg) || (score_reg == '0), "miss with nonzero score")
    `TTT_ASSERT(a_write_when, !sec_wr_en || (state_reg == ST_CLEAR) || (state_reg == ST_PRIM && op_reg == OP_RECORD), "table write outside clear or record")
    `TTT_ASSERT(a_result_lookup, !$rose(out_valid_reg) || (op_reg == OP_LOOKUP), "result produced for a record")

endmodule
